// ----- design/stack_machine_executor_assert.svh -----
// ---------------------------------------------------------------------------
// Stack machine executor assertion macros
// Shared property forms for the executor's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SME_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/sme_pkg.sv -----
// ---------------------------------------------------------------------------
// Stack machine executor package
// Command codes, data widths and shared types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sme_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned LIMIT_W = 31;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 31'd1000000000;

	// register index taken from paddr[2]
	localparam logic REG_IDX_LIMIT = 1'b0;

	typedef enum logic [3:0] {
		CMD_START = 4'd0,
		CMD_NUM   = 4'd1,
		CMD_POP   = 4'd2,
		CMD_INV   = 4'd3,
		CMD_DUP   = 4'd4,
		CMD_SWP   = 4'd5,
		CMD_ADD   = 4'd6,
		CMD_SUB   = 4'd7,
		CMD_MUL   = 4'd8,
		CMD_DIV   = 4'd9,
		CMD_MOD   = 4'd10,
		CMD_END   = 4'd11
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- design/sme_stack_ram.sv -----
// ---------------------------------------------------------------------------
// Stack store
// Single-port-write, single-port-read synchronous RAM, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sme_stack_ram
	import sme_pkg::*;
#(
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/sme_divider.sv -----
// ---------------------------------------------------------------------------
// Unsigned radix-2 divider
// Restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sme_divider
	import sme_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output div_stat_t         stat,
	output logic [DATA_W-1:0] quotient,
	output logic [DATA_W-1:0] remainder
);

	localparam int unsigned CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] quot_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvsr_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W+1:0] diff;

	assign shifted = {rem_q, quot_q[DATA_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			// restore on borrow, keep the difference otherwise
			rem_q  <= diff[DATA_W+1] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
			quot_q <= {quot_q[DATA_W-2:0], ~diff[DATA_W+1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;

endmodule

// ----- design/stack_machine_executor.sv -----
// ---------------------------------------------------------------------------
// Stack machine executor
// Runs one stack-machine instruction per input item, one at a time.
// ---------------------------------------------------------------------------
//  Channel   Dir  Contents
//  s_axis    in   tdata[3:0] cmd, tdata[35:4] value
//  m_axis    out  tuser ok, tdata[31:0] result_value (on end only)
//  apb       in   magnitude_limit at byte address 0
//
//  Top of stack sits in a register, the entries below it in the stack RAM.
//  Start, num, pop, inv, dup, swp, ignored items and underflow or overflow
//  finish in the execute state; add, sub and mul pass through arith and
//  check; div and mod wait in divw for the one-bit-per-cycle divider, unless
//  the divisor is zero. End holds while the output register is still full.
//  Reset empties the stack and clears the error; the RAM is not cleared.
//  A new item is taken once the previous one has been retired.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_machine_executor_assert.svh"

module stack_machine_executor
	import sme_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// instructions
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [3:0] cmd, [35:4] value, [39:36] zero
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] result_value
	output logic        m_axis_tuser    // [0] ok
);

	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW = $clog2(STACK_DEPTH);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_ARITH = 5'b00100,
		ST_DIVW  = 5'b01000,
		ST_CHECK = 5'b10000
	} state_t;

	state_t             state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic               err_q, err_d;
	logic [LIMIT_W-1:0] limit_q;
	logic [DATA_W-1:0]  tos_q, tos_d;
	logic [DATA_W-1:0]  nos_q, nos_d;
	logic [63:0]        res_q, res_d;
	cmd_t               cmd_q;
	logic [DATA_W-1:0]  val_q;

	logic               out_valid_q;
	logic               out_ok_q;
	logic [DATA_W-1:0]  out_val_q;
	logic               out_load;

	logic [CW-1:0]      cnt_m1, cnt_m2, cnt_p1;
	logic               cnt_zero, cnt_lt2, cnt_full;
	logic               in_acc;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [DATA_W-1:0]  mem_wdata;
	logic [DATA_W-1:0]  mem_rdata;

	logic               div_start;
	div_stat_t          div_stat;
	logic [DATA_W-1:0]  div_quot, div_rem;
	logic [DATA_W-1:0]  dvnd_mag, dvsr_mag;
	logic [DATA_W-1:0]  div_sel;
	logic               div_neg;
	logic [63:0]        div_mag64;
	logic signed [63:0] prod_w;
	logic [63:0]        lim64;
	logic               over_limit;
	logic               end_ok;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IDX_LIMIT) ? {1'b0, limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_LIMIT) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// ---------------- stack store ----------------
	assign cnt_m1   = count_q - CW'(1);
	assign cnt_m2   = count_q - CW'(2);
	assign cnt_p1   = count_q + CW'(1);
	assign cnt_zero = (count_q == '0);
	assign cnt_lt2  = (count_q < CW'(2));
	assign cnt_full = (count_q == CW'(STACK_DEPTH));

	// the entry below the top is always read; its registered data is used in the cycle after
	sme_stack_ram #(
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (cnt_m2[AW-1:0]),
		.rdata (mem_rdata)
	);

	// ---------------- divider ----------------
	assign dvnd_mag = nos_q[DATA_W-1] ? (DATA_W'(0) - nos_q) : nos_q;
	assign dvsr_mag = tos_q[DATA_W-1] ? (DATA_W'(0) - tos_q) : tos_q;

	sme_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (dvnd_mag),
		.divisor   (dvsr_mag),
		.stat      (div_stat),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// quotient signed by both operands, remainder by the dividend
	assign div_sel   = (cmd_q == CMD_DIV) ? div_quot : div_rem;
	assign div_neg   = (cmd_q == CMD_DIV) ? (nos_q[DATA_W-1] ^ tos_q[DATA_W-1])
	                                      : nos_q[DATA_W-1];
	assign div_mag64 = {32'd0, div_sel};

	assign prod_w = $signed(nos_q) * $signed(tos_q);

	assign lim64      = {33'd0, limit_q};
	assign over_limit = ($signed(res_q) > $signed(lim64)) || ($signed(res_q) < -$signed(lim64));

	assign end_ok = !err_q && (count_q == CW'(1));

	// ---------------- sequencer ----------------
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		err_d     = err_q;
		tos_d     = tos_q;
		nos_d     = nos_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = cnt_m1[AW-1:0];
		mem_wdata = tos_q;
		div_start = 1'b0;
		out_load  = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_EXEC;
				end
			end

			ST_EXEC: begin
				priority if (cmd_q == CMD_START) begin
					count_d = CW'(1);
					err_d   = 1'b0;
					tos_d   = val_q;
					state_d = ST_IDLE;
				end else if (cmd_q == CMD_END) begin
					// hold until the output register is free
					if (!out_valid_q || m_axis_tready) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (err_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_IDLE;
					unique case (cmd_q)
						CMD_NUM, CMD_DUP: begin
							if (cnt_full || (cmd_q == CMD_DUP && cnt_zero)) begin
								err_d = 1'b1;
							end else begin
								// spill the old top below the new one
								mem_we  = !cnt_zero;
								count_d = cnt_p1;
								if (cmd_q == CMD_NUM) begin
									tos_d = val_q;
								end
							end
						end
						CMD_POP: begin
							if (cnt_zero) begin
								err_d = 1'b1;
							end else begin
								count_d = cnt_m1;
								tos_d   = mem_rdata;
							end
						end
						CMD_INV: begin
							if (cnt_zero) begin
								err_d = 1'b1;
							end else begin
								tos_d = DATA_W'(0) - tos_q;
							end
						end
						CMD_SWP: begin
							if (cnt_lt2) begin
								err_d = 1'b1;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = cnt_m2[AW-1:0];
								tos_d     = mem_rdata;
							end
						end
						CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
							if (cnt_lt2) begin
								err_d = 1'b1;
							end else begin
								nos_d   = mem_rdata;
								state_d = ST_ARITH;
							end
						end
						default: begin
							// unused codes: drop
						end
					endcase
				end
			end

			ST_ARITH: begin
				unique case (cmd_q)
					CMD_ADD: begin
						res_d   = {{32{nos_q[31]}}, nos_q} + {{32{tos_q[31]}}, tos_q};
						state_d = ST_CHECK;
					end
					CMD_SUB: begin
						res_d   = {{32{nos_q[31]}}, nos_q} - {{32{tos_q[31]}}, tos_q};
						state_d = ST_CHECK;
					end
					CMD_MUL: begin
						res_d   = prod_w;
						state_d = ST_CHECK;
					end
					CMD_DIV, CMD_MOD: begin
						if (tos_q == '0) begin
							err_d   = 1'b1;
							state_d = ST_IDLE;
						end else begin
							div_start = 1'b1;
							state_d   = ST_DIVW;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end

			ST_DIVW: begin
				if (div_stat.done) begin
					res_d   = div_neg ? (64'd0 - div_mag64) : div_mag64;
					state_d = ST_CHECK;
				end
			end

			ST_CHECK: begin
				if (over_limit) begin
					err_d = 1'b1;
				end else begin
					count_d = cnt_m1;
					tos_d   = res_q[DATA_W-1:0];
				end
				state_d = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			err_q       <= err_d;
			out_valid_q <= out_load || (out_valid_q && !(m_axis_tvalid && m_axis_tready));
		end
	end

	always_ff @(posedge clk) begin
		tos_q <= tos_d;
		nos_q <= nos_d;
		res_q <= res_d;
		if (in_acc) begin
			cmd_q <= cmd_t'(s_axis_tdata[3:0]);
			val_q <= s_axis_tdata[35:4];
		end
		if (out_load) begin
			out_ok_q  <= end_ok;
			out_val_q <= end_ok ? tos_q : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_ok_q;
	assign m_axis_tdata  = out_val_q;

	// ---------------- assertions ----------------
	`SME_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(STACK_DEPTH), "stack count beyond depth")
	`SME_ASSERT_NEXT(a_accept_exec, clk, arst_n, in_acc, state_q == ST_EXEC, "accepted item not executed")
	`SME_ASSERT_NOW(a_div_done, clk, arst_n, div_stat.done, state_q == ST_DIVW, "divider result with no waiting op")
	`SME_ASSERT_NOW(a_fail_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "failed end carries a value")

endmodule
